/* rtl/spcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_pkg
// Types and constants shared by the stepper position command framer.
// ----------------------------------------------------------------------------
package spcf_pkg;

   // command modes
   localparam logic [1:0] MODE_ABS = 2'd0;
   localparam logic [1:0] MODE_REL = 2'd1;

   // motor addresses acted upon
   localparam logic [7:0] MOTOR_A = 8'd1;
   localparam logic [7:0] MOTOR_B = 8'd2;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFD;
   localparam logic [7:0] TAIL_BYTE = 8'h6B;
   localparam logic [7:0] PAD_BYTE  = 8'h00;

   // byte positions within the frame
   localparam logic [3:0] BI_MOTOR  = 4'd0;
   localparam logic [3:0] BI_SYNC   = 4'd1;
   localparam logic [3:0] BI_DIR    = 4'd2;
   localparam logic [3:0] BI_SPD_HI = 4'd3;
   localparam logic [3:0] BI_SPD_LO = 4'd4;
   localparam logic [3:0] BI_ACCEL  = 4'd5;
   localparam logic [3:0] BI_PLS_3  = 4'd6;
   localparam logic [3:0] BI_PLS_2  = 4'd7;
   localparam logic [3:0] BI_PLS_1  = 4'd8;
   localparam logic [3:0] BI_PLS_0  = 4'd9;
   localparam logic [3:0] BI_PAD_0  = 4'd10;
   localparam logic [3:0] BI_PAD_1  = 4'd11;
   localparam logic [3:0] BI_TAIL   = 4'd12;

   // arithmetic constants, angles in 1/80 degree
   localparam int unsigned PULSE_W = 20;
   localparam logic [25:0] Q_BIAS   = 26'd16777225;   // 25 * 671089, lifts turn count >= 0
   localparam logic [27:0] RECIP25  = 28'd171798691;  // floor(2^32 / 25)
   localparam logic [25:0] RECIP18  = 26'd59652323;   // floor(2^30 / 18)
   localparam logic signed [25:0] HALF_TURN = 26'sd14400;
   localparam logic signed [25:0] FULL_TURN = 26'sd28800;

   typedef struct packed {
      logic [7:0]  motor;
      logic        rel;
      logic [23:0] angle;
      logic [15:0] speed;
      logic [7:0]  accel;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic [7:0]         motor;
      logic               dir;
      logic [15:0]        speed;
      logic [7:0]         accel;
      logic [PULSE_W-1:0] pulses;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_slot_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SPLIT,
      CS_MUL1,
      CS_REM,
      CS_DIFF,
      CS_MUL2,
      CS_DONE
   } exec_state_type;

endpackage

/* rtl/spcf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_front
// Accepts command beats, drops those with an unknown mode or motor and
// queues the rest in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module spcf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_motor,
   input  logic signed [23:0]      req_angle,
   input  logic [15:0]             req_speed,
   input  logic [7:0]              req_accel,
   output spcf_pkg::queue_head_type head,
   input  logic                    pop
);

   spcf_pkg::cmd_type q_ff [2];
   spcf_pkg::cmd_type q_in [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              cmd_ok;
   logic              push;
   spcf_pkg::cmd_type cmd;

   assign req_stall = (count_ff == 2'd2);

   always_comb begin
      cmd_ok = ((req_mode == spcf_pkg::MODE_ABS) || (req_mode == spcf_pkg::MODE_REL)) &&
               ((req_motor == spcf_pkg::MOTOR_A) || (req_motor == spcf_pkg::MOTOR_B));
      push   = req_valid && !req_stall && cmd_ok;

      cmd.motor = req_motor;
      cmd.rel   = (req_mode == spcf_pkg::MODE_REL);
      cmd.angle = req_angle;
      cmd.speed = req_speed;
      cmd.accel = req_accel;

      q_in = q_ff;
      if (push) begin
         q_in[wr_ptr_ff] = cmd;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/spcf_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_exec
// Holds the two motor positions, works out direction and pulse count of
// one command over a short sequence and hands the finished frame on.
// ----------------------------------------------------------------------------
module spcf_exec (
   input  logic                     clock,
   input  logic                     reset,
   input  spcf_pkg::queue_head_type head,
   output logic                     pop,
   output spcf_pkg::frame_slot_type slot,
   input  logic                     take
);

   spcf_pkg::exec_state_type state_ff, state_in;
   spcf_pkg::cmd_type        cmd_ff, cmd_in;
   logic [31:0]              pos_ff [2];
   logic [31:0]              pos_in [2];
   logic [25:0]              u_ff, u_in;
   logic [6:0]               low_ff, low_in;
   logic [53:0]              prod_ff, prod_in;
   logic [11:0]              phase_ff, phase_in;
   logic [24:0]              n_ff, n_in;
   logic                     dir_ff, dir_in;
   logic [50:0]              prod2_ff, prod2_in;
   spcf_pkg::frame_type      res_ff, res_in;
   logic                     res_valid_ff, res_valid_in;

   logic                     idx;
   logic [31:0]              pos;
   logic [21:0]              quo;
   logic [25:0]              rem26;
   logic [5:0]               rem6;
   logic [4:0]               turn_rem;
   logic signed [25:0]       ang26;
   logic signed [25:0]       cur26;
   logic signed [25:0]       d26;
   logic [25:0]              mag26;
   logic [20:0]              p_est;
   logic [20:0]              p_sel;
   logic [24:0]              r25;
   logic [5:0]               r6;
   logic [spcf_pkg::PULSE_W-1:0] pulses;
   logic [31:0]              pulses32;

   assign idx = (cmd_ff.motor == spcf_pkg::MOTOR_B);
   assign pos = pos_ff[idx];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      u_in         = u_ff;
      low_in       = low_ff;
      prod_in      = prod_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      dir_in       = dir_ff;
      prod2_in     = prod2_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !take;
      pop          = 1'b0;

      // position modulo 3200: low 7 bits stay, turn count taken modulo 25
      quo      = prod_ff[53:32];
      rem26    = u_ff - ({quo, 4'b0} + {1'b0, quo, 3'b0} + {4'b0, quo});
      rem6     = rem26[5:0];
      turn_rem = (rem6 >= 6'd25) ? 5'(rem6 - 6'd25) : rem6[4:0];

      // difference to target: absolute mode folds it once by a full turn, relative mode takes the angle as is
      ang26 = {{2{cmd_ff.angle[23]}}, cmd_ff.angle};
      cur26 = signed'(26'({phase_ff, 3'b0}) + 26'(phase_ff));
      d26   = ang26 - cur26;
      if (!cmd_ff.rel) begin
         if (d26 > spcf_pkg::HALF_TURN) begin
            d26 = d26 - spcf_pkg::FULL_TURN;
         end else if (d26 < -spcf_pkg::HALF_TURN) begin
            d26 = d26 + spcf_pkg::FULL_TURN;
         end
      end else begin
         d26 = ang26;
      end
      mag26 = d26[25] ? 26'(-d26) : 26'(d26);

      // pulses = floor(n / 18), estimate may come out one low
      p_est    = prod2_ff[50:30];
      r25      = n_ff - (25'({p_est, 4'b0}) + 25'({p_est, 1'b0}));
      r6       = r25[5:0];
      p_sel    = (r6 >= 6'd18) ? (p_est + 21'd1) : p_est;
      pulses   = p_sel[spcf_pkg::PULSE_W-1:0];
      pulses32 = 32'(pulses);

      unique case (state_ff)
         spcf_pkg::CS_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cmd_in   = head.cmd;
               state_in = spcf_pkg::CS_SPLIT;
            end
         end
         spcf_pkg::CS_SPLIT: begin
            u_in     = 26'({pos[31], pos[31:7]}) + spcf_pkg::Q_BIAS;
            low_in   = pos[6:0];
            state_in = spcf_pkg::CS_MUL1;
         end
         spcf_pkg::CS_MUL1: begin
            prod_in  = 54'(u_ff) * 54'(spcf_pkg::RECIP25);
            state_in = spcf_pkg::CS_REM;
         end
         spcf_pkg::CS_REM: begin
            phase_in = {turn_rem, low_ff};
            state_in = spcf_pkg::CS_DIFF;
         end
         spcf_pkg::CS_DIFF: begin
            n_in     = 25'({mag26[23:0], 1'b0}) + 25'd9;
            dir_in   = d26[25];
            state_in = spcf_pkg::CS_MUL2;
         end
         spcf_pkg::CS_MUL2: begin
            prod2_in = 51'(n_ff) * 51'(spcf_pkg::RECIP18);
            state_in = spcf_pkg::CS_DONE;
         end
         spcf_pkg::CS_DONE: begin
            if (!res_valid_ff) begin
               res_in.motor  = cmd_ff.motor;
               res_in.dir    = dir_ff;
               res_in.speed  = cmd_ff.speed;
               res_in.accel  = cmd_ff.accel;
               res_in.pulses = pulses;
               res_valid_in  = 1'b1;
               pos_in[idx]   = dir_ff ? (pos - pulses32) : (pos + pulses32);
               state_in      = spcf_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = spcf_pkg::CS_IDLE;
         end
      endcase
   end

   assign slot.valid = res_valid_ff;
   assign slot.frame = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spcf_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0]    <= 32'd0;
         pos_ff[1]    <= 32'd0;
         res_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      u_ff     <= u_in;
      low_ff   <= low_in;
      prod_ff  <= prod_in;
      phase_ff <= phase_in;
      n_ff     <= n_in;
      dir_ff   <= dir_in;
      prod2_ff <= prod2_in;
      res_ff   <= res_in;
   end

endmodule

/* rtl/spcf_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_emit
// Serializes one finished frame into thirteen byte beats, most significant
// pulse byte first, and loads the next frame behind the last beat.
// ----------------------------------------------------------------------------
module spcf_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  spcf_pkg::frame_slot_type slot,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_last_byte
);

   spcf_pkg::frame_type frame_ff, frame_in;
   logic                valid_ff, valid_in;
   logic [3:0]          idx_ff, idx_in;
   logic                beat;
   logic                last;
   logic [31:0]         pulses32;

   always_comb begin
      last     = (idx_ff == spcf_pkg::BI_TAIL);
      beat     = valid_ff && !rsp_stall;
      take     = slot.valid && (!valid_ff || (beat && last));
      frame_in = frame_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (take) begin
         frame_in = slot.frame;
         valid_in = 1'b1;
         idx_in   = spcf_pkg::BI_MOTOR;
      end else if (beat) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   assign pulses32 = 32'(frame_ff.pulses);

   always_comb begin
      unique case (idx_ff)
         spcf_pkg::BI_MOTOR:  rsp_frame_byte = frame_ff.motor;
         spcf_pkg::BI_SYNC:   rsp_frame_byte = spcf_pkg::SYNC_BYTE;
         spcf_pkg::BI_DIR:    rsp_frame_byte = {7'b0, frame_ff.dir};
         spcf_pkg::BI_SPD_HI: rsp_frame_byte = frame_ff.speed[15:8];
         spcf_pkg::BI_SPD_LO: rsp_frame_byte = frame_ff.speed[7:0];
         spcf_pkg::BI_ACCEL:  rsp_frame_byte = frame_ff.accel;
         spcf_pkg::BI_PLS_3:  rsp_frame_byte = pulses32[31:24];
         spcf_pkg::BI_PLS_2:  rsp_frame_byte = pulses32[23:16];
         spcf_pkg::BI_PLS_1:  rsp_frame_byte = pulses32[15:8];
         spcf_pkg::BI_PLS_0:  rsp_frame_byte = pulses32[7:0];
         spcf_pkg::BI_PAD_0:  rsp_frame_byte = spcf_pkg::PAD_BYTE;
         spcf_pkg::BI_PAD_1:  rsp_frame_byte = spcf_pkg::PAD_BYTE;
         spcf_pkg::BI_TAIL:   rsp_frame_byte = spcf_pkg::TAIL_BYTE;
         default:             rsp_frame_byte = spcf_pkg::PAD_BYTE;
      endcase
   end

   assign rsp_valid     = valid_ff;
   assign rsp_last_byte = last;

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* rtl/stepper_position_command_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_command_framer
// Turns position commands into 13-byte stepper frames and tracks the pulse
// position of motors 1 and 2.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   mode, motor, angle, speed, accel
//   rsp      out        rsp_valid/rsp_stall   frame_byte, last_byte
//
// One frame byte leaves per cycle while rsp_stall is low; the byte serializer
// sets the command rate. The execution sequence (split, multiply, remainder,
// difference, multiply, done) overlaps the previous frame.
// Reset clears both positions to zero and empties the queue and serializer.
// A stalled output holds the current byte; the two-entry command queue then
// fills and req_stall rises. Commands with an unknown mode or motor are
// taken and dropped.
// ----------------------------------------------------------------------------
module stepper_position_command_framer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_motor,
   input  logic signed [23:0] req_angle,
   input  logic [15:0]        req_speed,
   input  logic [7:0]         req_accel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);

   spcf_pkg::queue_head_type head;
   spcf_pkg::frame_slot_type slot;
   logic                     pop;
   logic                     take;

   spcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_motor (req_motor),
      .req_angle (req_angle),
      .req_speed (req_speed),
      .req_accel (req_accel),
      .head      (head),
      .pop       (pop)
   );

   spcf_exec u_exec (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .slot  (slot),
      .take  (take)
   );

   spcf_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .slot           (slot),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

/* verif/spcf_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_frame_checker
// Watches the command and frame channels of the stepper position command
// framer. Keeps its own pulse position for motors 1 and 2, works out the
// 13-byte frame that each accepted command should produce, and compares
// every accepted frame byte against the oldest byte still owed.
// ----------------------------------------------------------------------------
module spcf_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_motor,
   input  logic signed [23:0] req_angle,
   input  logic [15:0]        req_speed,
   input  logic [7:0]         req_accel,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [7:0]         rsp_frame_byte,
   input  logic               rsp_last_byte,
   output int                 fail_count,
   output int                 bytes_owed
);

   localparam int PULSES_PER_REV = 3200;
   localparam int UNITS_PER_STEP = 9;
   localparam int HALF_REV_UNITS = 14400;
   localparam int FULL_REV_UNITS = 28800;
   localparam int FRAME_BYTES    = 13;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_beat_type;

   logic [31:0]    step_pos [2];
   frame_beat_type owed_q [$];

   function automatic void predict_frame(input logic [1:0] mode, input logic [7:0] motor,
                                         input logic signed [23:0] angle,
                                         input logic [15:0] speed, input logic [7:0] accel);
      int          slot;
      int          turn_units;
      int          delta;
      int          mag;
      logic [31:0] pulses;
      logic        dir;
      logic [7:0]  fb [FRAME_BYTES];
      if (mode != spcf_pkg::MODE_ABS && mode != spcf_pkg::MODE_REL) return;
      if (motor != spcf_pkg::MOTOR_A && motor != spcf_pkg::MOTOR_B) return;
      slot  = (motor == spcf_pkg::MOTOR_A) ? 0 : 1;
      delta = int'(angle);
      if (mode == spcf_pkg::MODE_ABS) begin
         // angle of the shaft now, from the position folded into one turn
         turn_units = $signed(step_pos[slot]) % PULSES_PER_REV;
         if (turn_units < 0) turn_units += PULSES_PER_REV;
         delta = delta - turn_units * UNITS_PER_STEP;
         // one correction only, far targets stay long
         if (delta > HALF_REV_UNITS) delta -= FULL_REV_UNITS;
         if (delta < -HALF_REV_UNITS) delta += FULL_REV_UNITS;
      end
      dir    = (delta < 0);
      mag    = dir ? -delta : delta;
      pulses = (2 * mag + UNITS_PER_STEP) / (2 * UNITS_PER_STEP);
      fb = '{motor, spcf_pkg::SYNC_BYTE, {7'd0, dir}, speed[15:8], speed[7:0], accel,
             pulses[31:24], pulses[23:16], pulses[15:8], pulses[7:0],
             spcf_pkg::PAD_BYTE, spcf_pkg::PAD_BYTE, spcf_pkg::TAIL_BYTE};
      foreach (fb[k])
         owed_q.push_back('{frame_byte: fb[k], last_byte: (k == FRAME_BYTES - 1)});
      step_pos[slot] = dir ? step_pos[slot] - pulses : step_pos[slot] + pulses;
   endfunction

   always @(posedge clock) begin : watch
      int             bad;
      frame_beat_type want;
      bad = 0;
      if (reset) begin
         step_pos[0] = '0;
         step_pos[1] = '0;
         owed_q.delete();
      end else begin
         // output side first, a beat can never belong to a command taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               $error("frame_byte %02h arrived with no frame owed", rsp_frame_byte);
               bad++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_frame_byte !== want.frame_byte) begin
                  $error("frame_byte: expected %02h, actual %02h",
                         want.frame_byte, rsp_frame_byte);
                  bad++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0b, actual %0b", want.last_byte, rsp_last_byte);
                  bad++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_frame(req_mode, req_motor, req_angle, req_speed, req_accel);
      end
      fail_count <= fail_count + bad;
      bytes_owed <= owed_q.size();
   end

endmodule

/* verif/tb_stepper_position_command_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_position_command_framer
// Drives position commands into the framer under three traffic patterns,
// holds the frame output off for long stretches, adds a run of large
// relative moves, and reports the verdict from the frame checker.
// ----------------------------------------------------------------------------
module tb_stepper_position_command_framer;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 90;
   localparam int WIND_MOVES = 8;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode       = '0;
   logic [7:0]         req_motor      = '0;
   logic signed [23:0] req_angle      = '0;
   logic [15:0]        req_speed      = '0;
   logic [7:0]         req_accel      = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last_byte;

   int fail_count;
   int bytes_owed;
   int send_idle_pct  = 7;
   int recv_stall_pct = 49;
   int hold_tickets   = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stepper_position_command_framer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_motor      (req_motor),
      .req_angle      (req_angle),
      .req_speed      (req_speed),
      .req_accel      (req_accel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   spcf_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_motor      (req_motor),
      .req_angle      (req_angle),
      .req_speed      (req_speed),
      .req_accel      (req_accel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte),
      .fail_count     (fail_count),
      .bytes_owed     (bytes_owed)
   );

   // frame receiver, a ticket buys one long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_tickets) begin
         rsp_stall    <= 1'b1;
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("FAIL stepper_position_command_framer");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cmd(input logic [1:0] mode, input logic [7:0] motor,
                           input logic signed [23:0] angle, input logic [15:0] speed,
                           input logic [7:0] accel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_motor <= motor;
      req_angle <= angle;
      req_speed <= speed;
      req_accel <= accel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_owed != 0);
   endtask

   task automatic send_random(output bit acted);
      logic [1:0]         mode;
      logic [7:0]         motor;
      logic signed [23:0] angle;
      if ($urandom_range(99) < 82) begin
         mode  = $urandom_range(1) ? spcf_pkg::MODE_REL : spcf_pkg::MODE_ABS;
         motor = $urandom_range(1) ? spcf_pkg::MOTOR_B : spcf_pkg::MOTOR_A;
      end else begin
         // noise, mostly dropped by the block
         mode  = 2'($urandom_range(3));
         motor = 8'($urandom_range(255));
      end
      case ($urandom_range(5))
         0:       angle = 24'($urandom);
         1, 2:    angle = 24'(int'($urandom_range(57600)) - 28800);
         3:       angle = 24'(int'($urandom_range(200)) - 100);
         4:       angle = 24'(int'($urandom_range(3199)) * 9);
         default: begin
            case ($urandom_range(5))
               0:       angle = 24'sd14400;
               1:       angle = -24'sd14400;
               2:       angle = 24'sd14401;
               3:       angle = -24'sd14401;
               4:       angle = 24'sh7FFFFF;
               default: angle = 24'sh800000;
            endcase
         end
      endcase
      send_cmd(mode, motor, angle, 16'($urandom), 8'($urandom));
      acted = (mode == spcf_pkg::MODE_ABS || mode == spcf_pkg::MODE_REL) &&
              (motor == spcf_pkg::MOTOR_A || motor == spcf_pkg::MOTOR_B);
   endtask

   task automatic run_random(input int acted_goal);
      int acted_total;
      bit acted;
      acted_total = 0;
      while (acted_total < acted_goal) begin
         send_random(acted);
         if (acted) acted_total++;
      end
   endtask

   // drive motor 2 up and motor 1 down by the largest relative moves, with an absolute move every 64th round
   task automatic wind_positions(input int moves);
      for (int n = 0; n < moves; n++) begin
         send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_B, 24'sh7FFFFF,
                  16'($urandom), 8'($urandom));
         send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, 24'sh800000,
                  16'($urandom), 8'($urandom));
         if (n % 64 == 0)
            send_cmd(spcf_pkg::MODE_ABS,
                     $urandom_range(1) ? spcf_pkg::MOTOR_A : spcf_pkg::MOTOR_B,
                     24'(int'($urandom_range(57600)) - 28800),
                     16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: rounding edges, half turn, far targets, extremes, dropped commands
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_A, 24'sd0, 16'h0000, 8'h00);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, 24'sd4, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, 24'sd5, 16'h00FF, 8'h01);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, -24'sd5, 16'hFF00, 8'h80);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_B, -24'sd4, 16'h1234, 8'h00);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_B, 24'sd14400, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_B, -24'sd14400, 16'h0001, 8'h7F);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_A, -24'sd14401, 16'h8000, 8'h00);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_A, 24'sh7FFFFF, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_B, 24'sh800000, 16'h0000, 8'h00);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, 24'sh7FFFFF, 16'hA5A5, 8'h5A);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, 24'sh800000, 16'h5A5A, 8'hA5);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_A, 24'sh800000, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_A, 24'sd100, 16'h0000, 8'h00);
      send_cmd(2'd2, spcf_pkg::MOTOR_A, 24'sd9000, 16'hFFFF, 8'hFF);
      send_cmd(2'd3, spcf_pkg::MOTOR_B, -24'sd9000, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_REL, 8'd0, 24'sd900, 16'h0000, 8'h00);
      send_cmd(spcf_pkg::MODE_ABS, 8'd3, 24'sd900, 16'h0000, 8'h00);
      send_cmd(spcf_pkg::MODE_REL, 8'd255, -24'sd900, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_ABS, 8'd255, 24'sh7FFFFF, 16'hFFFF, 8'hFF);
      send_cmd(spcf_pkg::MODE_REL, spcf_pkg::MOTOR_B, 24'sd28800, 16'h0400, 8'h10);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_B, 24'sd28800, 16'h0400, 8'h10);
      send_cmd(spcf_pkg::MODE_ABS, spcf_pkg::MOTOR_B, -24'sd28800, 16'h0400, 8'h10);

      hold_tickets <= hold_tickets + 1;
      run_random(80);
      drain_frames();

      send_idle_pct = 49;
      recv_stall_pct <= 7;
      run_random(80);
      drain_frames();

      send_idle_pct = 0;
      recv_stall_pct <= 0;
      hold_tickets <= hold_tickets + 1;
      run_random(80);
      wind_positions(WIND_MOVES);
      run_random(20);
      drain_frames();

      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASS stepper_position_command_framer");
      else
         $display("FAIL stepper_position_command_framer");
      $finish;
   end

endmodule

/* files.f */
rtl/spcf_pkg.sv
rtl/spcf_front.sv
rtl/spcf_exec.sv
rtl/spcf_emit.sv
rtl/stepper_position_command_framer.sv
verif/spcf_frame_checker.sv
verif/tb_stepper_position_command_framer.sv
